// ===== rtl/csvrs_pkg.sv =====
// Package for the CSV record splitter: item types, codes, character constants.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package csvrs_pkg;

  // Build limits; the result field widths below are sized for these values
  localparam int MAX_FIELDS      = 16;
  localparam int MAX_FIELD_BYTES = 4096;

  localparam int IDX_W = 5;   // field index; limit is clamped to MAX_FIELDS (5 bits)
  localparam int CNT_W = 13;  // byte count; limit is clamped to MAX_FIELD_BYTES (13 bits)

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic {
    ACT_DATA = 1'b0,
    ACT_END  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_REC_END = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_FIELDS    = 2'd1,
    ERR_TOO_LONG  = 2'd2,
    ERR_OPEN_QUOTE = 2'd3
  } err_t;

  typedef enum logic {
    REG_MAX_FIELDS = 1'b0,
    REG_STORE_SIZE = 1'b1
  } reg_index_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  field_number;
    logic [11:0] position;
    logic [7:0]  byte_out;
    logic [4:0]  field_count;
    err_t        error_code;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  max_fields;
    logic [12:0] store_size;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/csvrs_parse.sv =====
// Parser state and per-byte decode for the CSV record splitter.
// Depends on csvrs_pkg; produces at most one result per accepted request.
`default_nettype none

module csvrs_parse
  import csvrs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output logic           res_valid,
  output out_item_t      res
);

  logic             in_quotes, in_quotes_next;
  logic             quote_pending, quote_pending_next;
  logic             record_started, record_started_next;
  logic [IDX_W-1:0] field_index, field_index_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             error_halt, error_halt_next;

  logic [IDX_W-1:0] field_limit;
  logic [CNT_W-1:0] size_limit;

  // Clamp the registers to the build limits.
  always_comb begin
    if (32'(cfg.max_fields) > 32'(MAX_FIELDS)) field_limit = IDX_W'(MAX_FIELDS);
    else field_limit = cfg.max_fields;
    if (32'(cfg.store_size) > 32'(MAX_FIELD_BYTES)) size_limit = CNT_W'(MAX_FIELD_BYTES);
    else size_limit = cfg.store_size;
  end

  always_comb begin
    logic unquoted;
    logic keep;
    logic [7:0] b;
    in_quotes_next      = in_quotes;
    quote_pending_next  = quote_pending;
    record_started_next = record_started;
    field_index_next    = field_index;
    byte_count_next     = byte_count;
    error_halt_next     = error_halt;
    res_valid           = 1'b0;
    res                 = '0;
    unquoted            = 1'b1;
    keep                = 1'b0;
    b                   = item.byte_in;

    if (item.action == ACT_END) begin
      in_quotes_next      = 1'b0;
      quote_pending_next  = 1'b0;
      record_started_next = 1'b0;
      field_index_next    = '0;
      byte_count_next     = '0;
      error_halt_next     = 1'b0;
      if (!error_halt) begin
        res_valid = 1'b1;
        if (!record_started) begin
          res.kind = KIND_EMPTY;
        end else if (in_quotes && !quote_pending) begin
          res.kind       = KIND_ERROR;
          res.error_code = ERR_OPEN_QUOTE;
        end else begin
          res.kind        = KIND_REC_END;
          res.field_count = 5'(field_index) + 5'd1;
        end
      end
    end else if (!error_halt) begin
      record_started_next = 1'b1;
      if (quote_pending) begin
        quote_pending_next = 1'b0;
        if (b == CH_QUOTE) begin
          keep     = 1'b1;
          unquoted = 1'b0;
        end else begin
          in_quotes_next = 1'b0;
        end
      end else if (in_quotes) begin
        unquoted = 1'b0;
        if (b == CH_QUOTE) quote_pending_next = 1'b1;
        else keep = 1'b1;
      end

      if (unquoted) begin
        if (b == CH_QUOTE && byte_count == '0) begin
          in_quotes_next = 1'b1;
        end else if (b == CH_COMMA) begin
          if ({1'b0, field_index} + 6'd1 >= {1'b0, field_limit}) begin
            error_halt_next = 1'b1;
            res_valid       = 1'b1;
            res.kind        = KIND_ERROR;
            res.error_code  = ERR_FIELDS;
          end else begin
            field_index_next = field_index + IDX_W'(1);
            byte_count_next  = '0;
          end
        end else if (b == CH_LF) begin
          in_quotes_next      = 1'b0;
          quote_pending_next  = 1'b0;
          record_started_next = 1'b0;
          field_index_next    = '0;
          byte_count_next     = '0;
          res_valid           = 1'b1;
          res.kind            = KIND_REC_END;
          res.field_count     = 5'(field_index) + 5'd1;
        end else if (b != CH_CR) begin
          keep = 1'b1;
        end
      end

      if (keep) begin
        res_valid = 1'b1;
        if ({1'b0, byte_count} + 14'd1 >= {1'b0, size_limit}) begin
          // Byte is lost; the record halts until end of stream.
          error_halt_next = 1'b1;
          res.kind        = KIND_ERROR;
          res.error_code  = ERR_TOO_LONG;
        end else begin
          res.kind         = KIND_BYTE;
          res.field_number = field_index[3:0];
          res.position     = byte_count[11:0];
          res.byte_out     = b;
          byte_count_next  = byte_count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes      <= 1'b0;
      quote_pending  <= 1'b0;
      record_started <= 1'b0;
      field_index    <= '0;
      byte_count     <= '0;
      error_halt     <= 1'b0;
    end else if (accept) begin
      in_quotes      <= in_quotes_next;
      quote_pending  <= quote_pending_next;
      record_started <= record_started_next;
      field_index    <= field_index_next;
      byte_count     <= byte_count_next;
      error_halt     <= error_halt_next;
    end
  end

`ifndef ASSERT_OFF
  a_pending_in_quotes: assert property (@(posedge clk) disable iff (rst)
    quote_pending |-> in_quotes)
    else $error("quote pending outside quotes");
  a_idle_record_clear: assert property (@(posedge clk) disable iff (rst)
    !record_started |-> (field_index == '0 && byte_count == '0 && !in_quotes))
    else $error("record state set before any byte");
  a_halt_needs_record: assert property (@(posedge clk) disable iff (rst)
    error_halt |-> record_started)
    else $error("error halt without a started record");
`endif

endmodule

`default_nettype wire

// ===== rtl/csvrs_out_buf.sv =====
// Two-entry result buffer (output register plus skid) for the CSV splitter.
// Depends on csvrs_pkg; decouples the parser from the receiver's stall.
`default_nettype none

module csvrs_out_buf
  import csvrs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_item_t load_data,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      skid_valid;
  out_item_t skid_data;
  logic      take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // Upstream is held while the skid is occupied.
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (load) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) out_data <= skid_data;
    end else if (load) begin
      if (!out_valid || take) out_data <= load_data;
      else skid_data <= load_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csv_record_splitter_top.sv =====
// Top level of the CSV record splitter: config registers, parser, result buffer.
// Depends on csvrs_pkg, csvrs_parse and csvrs_out_buf.
`default_nettype none

// Usage:
//   Input channel (in_valid / in_stall / in_data): one request per byte of the
//   CSV stream (action = data) or an end-of-stream mark (action = end).
//   Output channel (out_valid / out_stall / out_data): zero or one result per
//   request: a field byte with its field number and position, a record end
//   with its field count, an error code, or an empty-stream mark.
//   Config port (cfg_we / cfg_index / cfg_wdata): index 0 is max_fields,
//   index 1 is the field store size; write only while the block is idle.
//   A result is loaded into the output register, or the skid on a stall,
//   once accepted. Throughput: one request per cycle while in_stall is low;
//   the parser logic between state and output registers is combinational.
//   When the receiver stalls, a two-entry buffer (output register plus skid)
//   absorbs one more result; in_stall then rises until the skid drains.
//   Reset (synchronous, rst high) clears the parser state and the buffer and
//   restores max_fields to 14 and the store size to 2048.
//   After an error, data bytes are dropped silently until the end mark, which
//   clears the error and gives no result.

module csv_record_splitter_top
  import csvrs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_wdata
);

  cfg_t      cfg;
  logic      accept;
  logic      res_valid;
  out_item_t res;
  logic      buf_full;

  // Config registers; writes are for the user to make only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_fields <= 5'd14;
      cfg.store_size <= 13'd2048;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_MAX_FIELDS: cfg.max_fields <= cfg_wdata[4:0];
        REG_STORE_SIZE: cfg.store_size <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold requests only while the skid entry is occupied.
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  csvrs_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  csvrs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res_valid),
    .load_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_stall_means_pending: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input held with no result waiting");
  a_error_has_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_ERROR) |-> out_data.error_code != ERR_NONE)
    else $error("error result without a code");
  a_rec_end_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_REC_END) |->
      (out_data.field_count != 5'd0 && out_data.error_code == ERR_NONE))
    else $error("record end with bad count or code");
`endif

endmodule

`default_nettype wire
